// ----- src/er7_pkg.sv -----
// Shared types and constants for the HL7 ER7 escape codec.
package er7_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_E         = 8'h45;
  localparam logic [7:0] CHAR_F         = 8'h46;
  localparam logic [7:0] CHAR_R         = 8'h52;
  localparam logic [7:0] CHAR_S         = 8'h53;
  localparam logic [7:0] CHAR_T         = 8'h54;

  localparam logic [7:0] RST_ESCAPE_CHAR       = 8'h5C;
  localparam logic [7:0] RST_FIELD_CHAR        = 8'h7C;
  localparam logic [7:0] RST_REPEAT_CHAR       = 8'h7E;
  localparam logic [7:0] RST_COMPONENT_CHAR    = 8'h5E;
  localparam logic [7:0] RST_SUBCOMPONENT_CHAR = 8'h26;

  typedef enum logic [2:0] {
    REG_UNESCAPE_MODE     = 3'd0,
    REG_FULL_SET          = 3'd1,
    REG_ESCAPE_CHAR       = 3'd2,
    REG_FIELD_CHAR        = 3'd3,
    REG_REPEAT_CHAR       = 3'd4,
    REG_COMPONENT_CHAR    = 3'd5,
    REG_SUBCOMPONENT_CHAR = 3'd6
  } er7_reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } er7_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
    logic       run_last;
  } er7_out_t;

  typedef struct packed {
    logic       unescape_mode;
    logic       full_set;
    logic [7:0] escape_char;
    logic [7:0] field_char;
    logic [7:0] repeat_char;
    logic [7:0] component_char;
    logic [7:0] subcomponent_char;
  } er7_cfg_t;

  // Results of one input item, entry 0 goes out first.
  typedef struct packed {
    logic [1:0]          cnt;
    er7_out_t [2:0]      ent;
  } er7_bundle_t;

endpackage

// ----- src/hl7_er7_escape_codec_unit.sv -----
// Top level of the HL7 ER7 escape codec.
// An accepted byte shows its first result in the next cycle, from a register.
// Each byte holds the input until its last result is taken: a plain byte has one
// result, an escaped delimiter three, a final unescape flush up to three.
// In unescape mode the first two bytes of a string give no result unless last.
// Reset (async, active low) restores register defaults and empties the stream state.
module hl7_er7_escape_codec_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  er7_pkg::er7_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output er7_pkg::er7_out_t out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);
  import er7_pkg::*;

  er7_cfg_t    cfg;
  er7_bundle_t bundle;
  logic        clear;
  logic        fire;
  logic        free;

  assign in_ready_o = free;
  assign fire       = in_valid_i & in_ready_o;

  er7_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clear_o     (clear)
  );

  er7_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .clear_i  (clear),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .bundle_o (bundle)
  );

  er7_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ----- src/er7_cfg_regs.sv -----
// Configuration register file of the ER7 codec.
module er7_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output er7_pkg::er7_cfg_t cfg_o,
  output logic              clear_o
);
  import er7_pkg::*;

  er7_cfg_t cfg_q, cfg_d;
  logic     wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (wr) begin
      case (cfg_index_i)
        REG_UNESCAPE_MODE: begin
          cfg_d.unescape_mode = cfg_data_i[0];
          clear_o             = 1'b1;
        end
        REG_FULL_SET:          cfg_d.full_set          = cfg_data_i[0];
        REG_ESCAPE_CHAR:       cfg_d.escape_char       = cfg_data_i;
        REG_FIELD_CHAR:        cfg_d.field_char        = cfg_data_i;
        REG_REPEAT_CHAR:       cfg_d.repeat_char       = cfg_data_i;
        REG_COMPONENT_CHAR:    cfg_d.component_char    = cfg_data_i;
        REG_SUBCOMPONENT_CHAR: cfg_d.subcomponent_char = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unescape_mode     <= 1'b0;
      cfg_q.full_set          <= 1'b1;
      cfg_q.escape_char       <= RST_ESCAPE_CHAR;
      cfg_q.field_char        <= RST_FIELD_CHAR;
      cfg_q.repeat_char       <= RST_REPEAT_CHAR;
      cfg_q.component_char    <= RST_COMPONENT_CHAR;
      cfg_q.subcomponent_char <= RST_SUBCOMPONENT_CHAR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/er7_step.sv -----
// Per-byte escape and unescape logic with the lookahead state.
module er7_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 clear_i,
  input  er7_pkg::er7_in_t     in_i,
  input  er7_pkg::er7_cfg_t    cfg_i,
  output er7_pkg::er7_bundle_t bundle_o
);
  import er7_pkg::*;

  typedef struct packed {
    logic skip;
    logic print;
    logic drop;
  } er7_flags_t;

  typedef struct packed {
    er7_flags_t flags;
    logic       emit;
    logic [7:0] data;
  } er7_dec_t;

  logic [7:0] la_q [2];
  logic [7:0] la_d [2];
  logic [1:0] buf_cnt_q, buf_cnt_d;
  logic [1:0] seen_q, seen_d;
  er7_flags_t flags_q, flags_d;

  function automatic er7_dec_t decode_pos(er7_flags_t f, logic [7:0] b, logic has_next,
                                          logic [7:0] nxt, er7_cfg_t c);
    er7_dec_t   r;
    logic       hit;
    logic [7:0] d;
    r     = '{flags: f, emit: 1'b0, data: b};
    hit   = 1'b1;
    d     = c.escape_char;
    if (nxt == CHAR_E) d = c.escape_char;
    else if (nxt == CHAR_F && c.full_set) d = c.field_char;
    else if (nxt == CHAR_R && c.full_set) d = c.repeat_char;
    else if (nxt == CHAR_S) d = c.component_char;
    else if (nxt == CHAR_T) d = c.subcomponent_char;
    else hit = 1'b0;
    if (f.drop) begin
      r.flags.drop = 1'b0;
    end else if (b != CHAR_BACKSLASH) begin
      r.emit = 1'b1;
    end else if (f.skip) begin
      r.flags.skip = 1'b0;
      if (f.print) begin
        r.emit        = 1'b1;
        r.data        = CHAR_BACKSLASH;
        r.flags.print = 1'b0;
      end
    end else begin
      r.flags.skip = 1'b1;
      if (has_next) begin
        r.emit = 1'b1;
        if (hit) begin
          r.data       = d;
          r.flags.drop = 1'b1;
        end else begin
          r.data        = CHAR_BACKSLASH;
          r.flags.print = 1'b1;
        end
      end
    end
    return r;
  endfunction

  er7_dec_t   dec0, dec1, dec2;
  logic [1:0] total;
  logic [1:0] n;
  logic       ln0, ln1, ln2;
  logic [7:0] lb0, lb1, lb2;
  logic [7:0] b;
  logic       last;

  assign b    = in_i.in_byte;
  assign last = in_i.in_last;

  always_comb begin
    dec0 = decode_pos(flags_q, la_q[0], 1'b1, la_q[1], cfg_i);
    dec1 = decode_pos(dec0.flags, la_q[1], 1'b0, 8'h00, cfg_i);
    dec2 = decode_pos(dec1.flags, b, 1'b0, 8'h00, cfg_i);
  end

  always_comb begin
    total     = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
    la_d      = la_q;
    buf_cnt_d = buf_cnt_q;
    seen_d    = seen_q;
    flags_d   = flags_q;
    {ln0, ln1, ln2} = 3'b000;
    {lb0, lb1, lb2} = {3{8'h00}};
    if (!cfg_i.unescape_mode) begin
      if (b == cfg_i.escape_char) begin
        {ln0, ln1, ln2} = 3'b111;
        {lb0, lb1, lb2} = {CHAR_BACKSLASH, CHAR_E, CHAR_BACKSLASH};
      end else if (cfg_i.full_set && b == cfg_i.field_char) begin
        {ln0, ln1, ln2} = 3'b111;
        {lb0, lb1, lb2} = {CHAR_BACKSLASH, CHAR_F, CHAR_BACKSLASH};
      end else if (cfg_i.full_set && b == cfg_i.repeat_char) begin
        {ln0, ln1, ln2} = 3'b111;
        {lb0, lb1, lb2} = {CHAR_BACKSLASH, CHAR_R, CHAR_BACKSLASH};
      end else if (b == cfg_i.component_char) begin
        {ln0, ln1, ln2} = 3'b111;
        {lb0, lb1, lb2} = {CHAR_BACKSLASH, CHAR_S, CHAR_BACKSLASH};
      end else if (b == cfg_i.subcomponent_char) begin
        {ln0, ln1, ln2} = 3'b111;
        {lb0, lb1, lb2} = {CHAR_BACKSLASH, CHAR_T, CHAR_BACKSLASH};
      end else begin
        ln0 = 1'b1;
        lb0 = b;
      end
    end else if (!last) begin
      if (buf_cnt_q >= 2'd2) begin
        ln0     = dec0.emit;
        lb0     = dec0.data;
        flags_d = dec0.flags;
        la_d[0] = la_q[1];
        la_d[1] = b;
      end else begin
        la_d[buf_cnt_q[0]] = b;
        buf_cnt_d          = buf_cnt_q + 2'd1;
      end
      seen_d = total;
    end else begin
      if (total != 2'd3) begin
        // Short string: replay what is held, then this byte
        ln0 = buf_cnt_q >= 2'd1;
        lb0 = la_q[0];
        ln1 = buf_cnt_q >= 2'd2;
        lb1 = la_q[1];
        ln2 = 1'b1;
        lb2 = b;
      end else begin
        ln0 = dec0.emit;
        lb0 = dec0.data;
        ln1 = dec1.emit;
        lb1 = dec1.data;
        ln2 = dec2.emit;
        lb2 = dec2.data;
      end
      buf_cnt_d = 2'd0;
      seen_d    = 2'd0;
      flags_d   = '0;
    end
  end

  // Pack the emitted bytes towards entry 0 and tag the final one.
  always_comb begin
    bundle_o.ent = '0;
    n            = 2'd0;
    if (ln0) begin
      bundle_o.ent[n] = '{out_byte: lb0, byte_valid: 1'b1, string_end: 1'b0, run_last: 1'b0};
      n = n + 2'd1;
    end
    if (ln1) begin
      bundle_o.ent[n] = '{out_byte: lb1, byte_valid: 1'b1, string_end: 1'b0, run_last: 1'b0};
      n = n + 2'd1;
    end
    if (ln2) begin
      bundle_o.ent[n] = '{out_byte: lb2, byte_valid: 1'b1, string_end: 1'b0, run_last: 1'b0};
      n = n + 2'd1;
    end
    if (n == 2'd0 && cfg_i.unescape_mode && last) begin
      // Empty flush: end marker only
      bundle_o.ent[0] = '0;
      n = 2'd1;
    end
    if (n != 2'd0) begin
      bundle_o.ent[n - 2'd1].run_last   = 1'b1;
      bundle_o.ent[n - 2'd1].string_end = last;
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= 2'd0;
      seen_q    <= 2'd0;
      flags_q   <= '0;
    end else if (clear_i) begin
      buf_cnt_q <= 2'd0;
      seen_q    <= 2'd0;
      flags_q   <= '0;
    end else if (fire_i) begin
      buf_cnt_q <= buf_cnt_d;
      seen_q    <= seen_d;
      flags_q   <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      la_q <= la_d;
    end
  end

endmodule

// ----- src/er7_out_buf.sv -----
// Result register that hands out up to three results, one per transfer.
module er7_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  er7_pkg::er7_bundle_t bundle_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output er7_pkg::er7_out_t    out_o
);
  import er7_pkg::*;

  er7_out_t [2:0] ent_q;
  logic [1:0]     cnt_q;
  logic           pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o & out_ready_i;
  assign free_o      = (cnt_q == 2'd0) | ((cnt_q == 2'd1) & out_ready_i);
  assign out_o       = ent_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= bundle_i.ent;
    end else if (pop) begin
      // advance the queue
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule

// ----- src/er7_checker.sv -----
// Port-level checks for the ER7 codec, bound to the top level.
module er7_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input er7_pkg::er7_out_t out_o
);
  import er7_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.string_end |-> out_o.run_last)
    else $error("string end not on last result of its byte");

  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.byte_valid |->
      out_o.out_byte == 8'h00 && out_o.string_end && out_o.run_last)
    else $error("malformed end marker");

  // A byte that yields results blocks input until its results drain
  a_mid_run_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.run_last |-> !in_ready_o)
    else $error("input taken while a byte still has results queued");

endmodule

bind hl7_er7_escape_codec_unit er7_checker u_er7_checker (.*);
